// ===== rtl/mecanum_goto_pose_controller_macros.svh =====
// Assertion macros for the go-to-pose controller.
`ifndef MECANUM_GOTO_POSE_CONTROLLER_MACROS_SVH
`define MECANUM_GOTO_POSE_CONTROLLER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MGP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MGP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/mgp_pkg.sv =====
// Shared constants, types and tables for the go-to-pose controller.
`timescale 1ns / 1ps
package mgp_pkg;
  localparam int CordicStepsDefault = 16;
  localparam int FracBitsDefault    = 16;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_TARGET_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TARGET_HEADING = 2'd2;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint ThreeOverPiQ30 = 64'sd1025347913;
  localparam longint SpeedLimit = 64'sd262144;
  localparam longint PosTolSq = 64'sd4295;
  localparam longint AngTol = 64'sd65;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_MUL, ST_MIX, ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } cordic_ctl_t;

  function automatic longint atan_q30(input int i);
    case (i)
      0: return 843314857;  1: return 497837829;  2: return 263043837;
      3: return 133525159;  4: return 67021687;   5: return 33543516;
      6: return 16775851;   7: return 8388437;    8: return 4194283;
      9: return 2097149;
      default: return (i >= 31) ? 64'sd0 : (64'sd1 <<< (30 - i));
    endcase
  endfunction

  // Round-half-up arithmetic shift of a Q30 constant to F fraction bits.
  function automatic longint q30_to_frac(input longint c, input int f);
    longint r;
    if (f >= 30) r = c;
    else r = (c + (64'sd1 <<< (29 - f))) >>> (30 - f);
    return r;
  endfunction
endpackage

// ===== rtl/mgp_cordic.sv =====
// Iterative CORDIC vectoring unit: one rotation step per cycle.
`timescale 1ns / 1ps
module mgp_cordic #(
  parameter int CORDIC_STEPS = mgp_pkg::CordicStepsDefault,
  parameter int FRAC_BITS    = mgp_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] hx,
  input  logic signed [15:0] hy,
  output mgp_pkg::cordic_ctl_t ctl,
  output logic signed [33:0] theta
);
  localparam int VW = 36;
  localparam int AW = FRAC_BITS + 5;
  localparam int IW = $clog2(CORDIC_STEPS + 1);

  logic signed [VW-1:0] x, y, x_sh, y_sh;
  logic signed [AW-1:0] acc, t;
  logic [IW-1:0] step;
  logic busy, done;
  logic signed [VW-1:0] hx_e, hy_e;
  logic signed [AW-1:0] hp;

  assign hx_e = VW'(hx) <<< 16;
  assign hy_e = VW'(hy) <<< 16;
  assign hp = AW'(mgp_pkg::q30_to_frac(mgp_pkg::HalfPiQ30, FRAC_BITS));
  assign x_sh = x >>> step;
  assign y_sh = y >>> step;
  always_comb begin
    t = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (step == IW'(i)) t = AW'(mgp_pkg::q30_to_frac(mgp_pkg::atan_q30(i), FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !(hx == 0 && hy == 0);
        done <= (hx == 0 && hy == 0);
      end else if (busy && step == IW'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      if (hx < 0) begin
        if (hy >= 0) begin
          x <= hy_e; y <= -hx_e; acc <= hp;
        end else begin
          x <= -hy_e; y <= hx_e; acc <= -hp;
        end
      end else begin
        x <= hx_e; y <= hy_e; acc <= '0;
      end
    end else if (busy) begin
      step <= step + 1'b1;
      if (y >= 0) begin
        x <= x + y_sh; y <= y - x_sh; acc <= acc + t;
      end else begin
        x <= x - y_sh; y <= y + x_sh; acc <= acc - t;
      end
    end
  end

  always_comb begin
    if (FRAC_BITS >= 16)
      theta = 34'((64'(acc) + ((FRAC_BITS > 16) ? (64'sd1 <<< (FRAC_BITS - 17)) : 64'sd0))
              >>> (FRAC_BITS - 16));
    else
      theta = 34'(64'(acc) <<< (16 - FRAC_BITS));
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
endmodule

// ===== rtl/mgp_serial_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps
module mgp_serial_mul #(
  parameter int AW = 34,
  parameter int BW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic                  done,
  output logic signed [AW+BW-1:0] p
);
  localparam int CW = $clog2(BW + 1);
  logic signed [AW+BW-1:0] acc, mcand;
  logic [BW-1:0] mplier;
  logic [CW-1:0] cnt;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == CW'(BW - 1);
      if (start) busy <= 1'b1;
      else if (busy && cnt == CW'(BW - 1)) busy <= 1'b0;
    end
  end

  // Two's complement: top multiplier bit has negative weight.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mcand <= (AW+BW)'(a);
      mplier <= b;
      cnt <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        if (cnt == CW'(BW - 1)) acc <= acc - mcand;
        else acc <= acc + mcand;
      end
      mcand <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt <= cnt + 1'b1;
    end
  end
  assign p = acc;
endmodule

// ===== rtl/mecanum_goto_pose_controller.sv =====
// Top level of the mecanum go-to-pose controller.
// Sequence: an accepted input runs the iterative CORDIC and then the bit-serial multipliers
//   (a zero compass vector skips the CORDIC iterations) before the result is valid.
// Occupancy: one transaction in flight; the iterative CORDIC is followed by five bit-serial
//   multipliers sharing one pass.
// Reset (rst, synchronous): targets cleared to 0, reached flag cleared, output empty.
// Input is taken again once the result register has been emptied.
`timescale 1ns / 1ps
`include "mecanum_goto_pose_controller_macros.svh"
module mecanum_goto_pose_controller #(
  parameter int CORDIC_STEPS = mgp_pkg::CordicStepsDefault,
  parameter int FRAC_BITS    = mgp_pkg::FracBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [mgp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] heading_x,
  input  logic signed [15:0] heading_y,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [19:0] wheel_front_left,
  output logic signed [19:0] wheel_front_right,
  output logic signed [19:0] wheel_rear_left,
  output logic signed [19:0] wheel_rear_right,
  output logic target_reached
);
  mgp_pkg::ctl_state_t state, state_next;
  logic signed [31:0] target_x, target_y, target_heading;
  logic reached_flag;
  logic signed [32:0] dx, dy;
  logic signed [15:0] hx, hy;
  logic signed [33:0] theta, delta;
  mgp_pkg::cordic_ctl_t cctl;
  logic accept, cordic_start, mul_start;
  logic cfg_clear;
  logic [4:0] mul_done;
  logic signed [65:0] p_k;
  logic signed [48:0] p_hydx, p_hxdy, p_hxdx, p_hydy;
  logic signed [49:0] ru_sum, rv_sum;
  logic signed [36:0] k, ru, rv;
  logic signed [65:0] dd;
  logic signed [33:0] dx2, dy2;
  logic signed [39:0] s0, s1, s2, s3;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == mgp_pkg::ST_IDLE);

  // Writes to a known register clear the sticky flag; unknown indexes are ignored.
  assign cfg_clear = cfg_we && (cfg_index inside {mgp_pkg::REG_TARGET_X,
                                                  mgp_pkg::REG_TARGET_Y,
                                                  mgp_pkg::REG_TARGET_HEADING});

  // Target registers; any valid write clears the sticky flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0; target_y <= '0; target_heading <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mgp_pkg::REG_TARGET_X: target_x <= cfg_data;
        mgp_pkg::REG_TARGET_Y: target_y <= cfg_data;
        mgp_pkg::REG_TARGET_HEADING: target_heading <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx <= 33'(target_x) - 33'(pos_x);
      dy <= 33'(target_y) - 33'(pos_y);
      hx <= heading_x;
      hy <= heading_y;
    end
  end
  assign cordic_start = accept;

  mgp_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start), .hx(heading_x), .hy(heading_y),
    .ctl(cctl), .theta(theta));

  always_ff @(posedge clk) begin
    if (cctl.done) delta <= -theta - 34'(target_heading);
  end
  assign mul_start = (state == mgp_pkg::ST_CORDIC) && cctl.done;
  logic mul_go;
  always_ff @(posedge clk) begin
    if (rst) mul_go <= 1'b0;
    else mul_go <= mul_start;
  end

  // Five bit-serial products run side by side: 3/pi*delta and the rotation.
  mgp_serial_mul #(.AW(34), .BW(32)) u_mk (.clk(clk), .rst(rst), .start(mul_go),
    .a(delta), .b(32'(mgp_pkg::ThreeOverPiQ30)), .done(mul_done[0]), .p(p_k));
  mgp_serial_mul #(.AW(33), .BW(16)) u_m1 (.clk(clk), .rst(rst), .start(mul_go),
    .a(dx), .b(hy), .done(mul_done[1]), .p(p_hydx));
  mgp_serial_mul #(.AW(33), .BW(16)) u_m2 (.clk(clk), .rst(rst), .start(mul_go),
    .a(dy), .b(hx), .done(mul_done[2]), .p(p_hxdy));
  mgp_serial_mul #(.AW(33), .BW(16)) u_m3 (.clk(clk), .rst(rst), .start(mul_go),
    .a(dx), .b(hx), .done(mul_done[3]), .p(p_hxdx));
  mgp_serial_mul #(.AW(33), .BW(16)) u_m4 (.clk(clk), .rst(rst), .start(mul_go),
    .a(dy), .b(hy), .done(mul_done[4]), .p(p_hydy));

  logic mix_go;
  always_ff @(posedge clk) begin
    if (rst) mix_go <= 1'b0;
    else mix_go <= mul_done[0];
  end

  // Stage 1 of the mix: round products down to Q16.16.
  // The 16-bit products finish early and hold; the 32-bit one sets the pace.
  assign ru_sum = 50'(p_hydx) + 50'(p_hxdy) + 50'sd8192;
  assign rv_sum = 50'(p_hxdx) - 50'(p_hydy) + 50'sd8192;
  always_ff @(posedge clk) begin
    if (mul_done[0]) begin
      k  <= 37'((p_k + 66'sd536870912) >>> 30);
      ru <= 37'(ru_sum >>> 14);
      rv <= 37'(rv_sum >>> 14);
    end
  end

  function automatic logic signed [19:0] sat(input logic signed [39:0] v);
    logic signed [44:0] m;
    m = 45'(v) * 45'sd24;
    if (m > 45'(mgp_pkg::SpeedLimit)) return 20'(mgp_pkg::SpeedLimit);
    if (m < -45'(mgp_pkg::SpeedLimit)) return -20'(mgp_pkg::SpeedLimit);
    return 20'(m);
  endfunction

  assign s0 = -40'(k) + 40'(ru) - 40'(rv);
  assign s1 =  40'(k) + 40'(ru) + 40'(rv);
  assign s2 = -40'(k) + 40'(ru) + 40'(rv);
  assign s3 =  40'(k) + 40'(ru) - 40'(rv);

  // Near-target test only on small errors; squares fit narrow.
  logic near;
  logic signed [16:0] dxs, dys;
  assign near = (dx > -33'sd65536) && (dx < 33'sd65536) &&
                (dy > -33'sd65536) && (dy < 33'sd65536);
  assign dxs = dx[16:0];
  assign dys = dy[16:0];
  assign dx2 = 34'(dxs) * 34'(dxs);
  assign dy2 = 34'(dys) * 34'(dys);
  assign dd = 66'(dx2) + 66'(dy2);

  always_ff @(posedge clk) begin
    if (rst) reached_flag <= 1'b0;
    else if (cfg_clear) reached_flag <= 1'b0;
    else if (mix_go && near && dd < 66'(mgp_pkg::PosTolSq) &&
             delta >= -34'(mgp_pkg::AngTol) && delta <= 34'(mgp_pkg::AngTol))
      reached_flag <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == mgp_pkg::ST_MIX) begin
      wheel_front_left  <= sat(s0);
      wheel_front_right <= sat(s1);
      wheel_rear_left   <= sat(s2);
      wheel_rear_right  <= sat(s3);
    end
  end
  assign target_reached = reached_flag;

  always_ff @(posedge clk) begin
    if (rst) state <= mgp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      mgp_pkg::ST_IDLE:   if (accept) state_next = mgp_pkg::ST_CORDIC;
      mgp_pkg::ST_CORDIC: if (cctl.done) state_next = mgp_pkg::ST_MUL;
      mgp_pkg::ST_MUL:    if (mix_go) state_next = mgp_pkg::ST_MIX;
      mgp_pkg::ST_MIX:    state_next = mgp_pkg::ST_OUT;
      mgp_pkg::ST_OUT:    if (out_ready) state_next = mgp_pkg::ST_IDLE;
      default:            state_next = mgp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state == mgp_pkg::ST_OUT);
  end

  `MGP_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, !out_valid && !cctl.busy)
  `MGP_ASSERT_IMP(a_mul_sync, clk, rst, mul_done[1], mul_done[4:1] == 4'b1111)
  `MGP_ASSERT_NXT(a_cfg_clear, clk, rst, cfg_clear, !reached_flag)
endmodule
